>>> rtl/tfn_pkg.sv
// Shared widths, the register address and the sideband type for the face normal pipeline.
package tfn_pkg;

   // Fraction bits of the unit normal.
   localparam int FRAC_BITS = 14;

   // Vertex and edge widths.
   localparam int COORD_W = 32;
   localparam int EDGE_W = COORD_W + 1;
   localparam int PROD_W = 2 * EDGE_W;
   localparam int DIFF_W = PROD_W + 1;
   localparam int CRS_W = PROD_W;
   localparam int LEN_W = 7;

   // Reduced magnitudes, their squares and the sum of squares.
   localparam int M_W = 31;
   localparam int SQ_W = 2 * M_W;
   localparam int SUM_W = 64;

   // Divider and square root widths.
   localparam int QUO_W = 2 * FRAC_BITS + 3;
   localparam int REM_W = SQ_W + 2 * FRAC_BITS + 2;
   localparam int CMP_W = SUM_W + QUO_W;
   localparam int ROOT_W = FRAC_BITS + 2;
   localparam int NORM_W = 16;

   // Register map.
   localparam int ADDR_W = 3;
   localparam logic [ADDR_W-1:0] ADDR_FLIP = 3'd0;

   // Sideband that travels beside the three lanes.
   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } side_type;

endpackage

>>> rtl/tfn_cross.sv
// Edge vectors and exact cross product, four register stages.
module tfn_cross (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [2:0][tfn_pkg::COORD_W-1:0]     vert_a,
   input  logic [2:0][tfn_pkg::COORD_W-1:0]     vert_b,
   input  logic [2:0][tfn_pkg::COORD_W-1:0]     vert_c,
   output logic                                 out_valid,
   output logic [2:0][tfn_pkg::CRS_W-1:0]       mag,
   output logic [2:0]                           neg
);
   import tfn_pkg::*;

   logic [3:0] vld_ff;
   logic signed [EDGE_W-1:0] e1_ff [3];
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic signed [PROD_W-1:0] p1_ff [3];
   logic signed [PROD_W-1:0] p2_ff [3];
   logic signed [DIFF_W-1:0] d_ff [3];
   logic [2:0][CRS_W-1:0] mag_ff;
   logic [2:0] neg_ff;

   // Valid bits advance with the pipeline enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      logic signed [DIFF_W-1:0] abs_src;

      assign abs_src = d_ff[i];

      // Edges, products, difference and magnitude, one step per stage.
      always_ff @(posedge clock) begin
         if (en) begin
            e1_ff[i] <= $signed({vert_c[i][COORD_W-1], vert_c[i]})
                        - $signed({vert_a[i][COORD_W-1], vert_a[i]});
            e2_ff[i] <= $signed({vert_c[i][COORD_W-1], vert_c[i]})
                        - $signed({vert_b[i][COORD_W-1], vert_b[i]});
            p1_ff[i] <= e1_ff[J] * e2_ff[K];
            p2_ff[i] <= e1_ff[K] * e2_ff[J];
            d_ff[i] <= $signed({p1_ff[i][PROD_W-1], p1_ff[i]})
                       - $signed({p2_ff[i][PROD_W-1], p2_ff[i]});
            neg_ff[i] <= abs_src[DIFF_W-1];
            mag_ff[i] <= abs_src[DIFF_W-1] ? CRS_W'(-abs_src) : abs_src[CRS_W-1:0];
         end
      end
   end

   assign out_valid = vld_ff[3];
   assign mag = mag_ff;
   assign neg = neg_ff;

endmodule

>>> rtl/tfn_norm.sv
// Reduces the cross product to 31-bit magnitudes and forms the sum of squares.
module tfn_norm (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [2:0][tfn_pkg::CRS_W-1:0]     mag,
   input  logic [2:0]                         neg,
   output logic                               out_valid,
   output logic [2:0][tfn_pkg::SQ_W-1:0]      sq,
   output logic [tfn_pkg::SUM_W-1:0]          sum,
   output tfn_pkg::side_type                  side
);
   import tfn_pkg::*;

   logic [2:0] vld_ff;
   logic [CRS_W-1:0] any_bits;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] shift;
   logic [2:0][M_W-1:0] m_ff;
   logic [2:0][SQ_W-1:0] sq_ff;
   logic [2:0][SQ_W-1:0] sq2_ff;
   logic [SUM_W-1:0] sum_ff;
   side_type side_ff [3];

   // Bit length of the largest magnitude and the shift that brings it to 31 bits.
   always_comb begin
      any_bits = mag[0] | mag[1] | mag[2];
      len = '0;
      for (int b = 0; b < CRS_W; b++) begin
         if (any_bits[b]) begin
            len = LEN_W'(b + 1);
         end
      end
      shift = (len > LEN_W'(M_W)) ? len - LEN_W'(M_W) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   // Shift, square, then sum.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            m_ff[i] <= M_W'(mag[i] >> shift);
            sq_ff[i] <= SQ_W'(m_ff[i]) * SQ_W'(m_ff[i]);
         end
         side_ff[0] <= '{neg: neg, degen: (len == '0)};
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         sq2_ff <= sq_ff;
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      end
   end

   assign out_valid = vld_ff[2];
   assign sq = sq2_ff;
   assign sum = sum_ff;
   assign side = side_ff[2];

endmodule

>>> rtl/tfn_div.sv
// Restoring divider, one quotient bit per stage, three lanes sharing one divisor.
module tfn_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [2:0][tfn_pkg::SQ_W-1:0]      sq,
   input  logic [tfn_pkg::SUM_W-1:0]          sum,
   input  tfn_pkg::side_type                  side_in,
   output logic                               out_valid,
   output logic [2:0][tfn_pkg::QUO_W-1:0]     quo,
   output tfn_pkg::side_type                  side_out
);
   import tfn_pkg::*;

   logic [QUO_W-1:0] vld_ff;
   logic [2:0][REM_W-1:0] rem_ff [QUO_W];
   logic [2:0][QUO_W-1:0] quo_ff [QUO_W];
   logic [SUM_W-1:0] dvs_ff [QUO_W];
   side_type side_ff [QUO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QUO_W-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int J = QUO_W - 1 - k;
      logic [2:0][REM_W-1:0] rem_prev;
      logic [2:0][QUO_W-1:0] quo_prev;
      logic [SUM_W-1:0] dvs_prev;
      side_type side_prev;

      if (k == 0) begin : g_first
         for (genvar i = 0; i < 3; i++) begin : g_init
            assign rem_prev[i] = REM_W'(sq[i]) << (2 * FRAC_BITS + 2);
         end
         assign quo_prev = '0;
         assign dvs_prev = sum;
         assign side_prev = side_in;
      end else begin : g_rest
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign dvs_prev = dvs_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // Trial subtraction of the shifted divisor in each lane.
      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               if (CMP_W'(rem_prev[i]) >= (CMP_W'(dvs_prev) << J)) begin
                  rem_ff[k][i] <= REM_W'(CMP_W'(rem_prev[i]) - (CMP_W'(dvs_prev) << J));
                  quo_ff[k][i] <= quo_prev[i] | (QUO_W'(1) << J);
               end else begin
                  rem_ff[k][i] <= rem_prev[i];
                  quo_ff[k][i] <= quo_prev[i];
               end
            end
            dvs_ff[k] <= dvs_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign quo = quo_ff[QUO_W-1];
   assign side_out = side_ff[QUO_W-1];

endmodule

>>> rtl/tfn_isqrt.sv
// Integer square root, one root bit per stage, three lanes.
module tfn_isqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [2:0][tfn_pkg::QUO_W-1:0]     rad,
   input  tfn_pkg::side_type                  side_in,
   output logic                               out_valid,
   output logic [2:0][tfn_pkg::ROOT_W-1:0]    root,
   output tfn_pkg::side_type                  side_out
);
   import tfn_pkg::*;

   logic [ROOT_W-1:0] vld_ff;
   logic [2:0][ROOT_W-1:0] root_ff [ROOT_W];
   logic [2:0][QUO_W-1:0] rad_ff [ROOT_W];
   side_type side_ff [ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ROOT_W-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [2:0][ROOT_W-1:0] root_prev;
      logic [2:0][QUO_W-1:0] rad_prev;
      side_type side_prev;
      logic [2:0][ROOT_W-1:0] cand;
      logic [2:0][2*ROOT_W-1:0] cand_sq;

      if (k == 0) begin : g_first
         assign root_prev = '0;
         assign rad_prev = rad;
         assign side_prev = side_in;
      end else begin : g_rest
         assign root_prev = root_ff[k-1];
         assign rad_prev = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // Keep the trial bit when its square still fits under the radicand.
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            cand[i] = root_prev[i] | (ROOT_W'(1) << B);
            cand_sq[i] = (2*ROOT_W)'(cand[i]) * (2*ROOT_W)'(cand[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               root_ff[k][i] <= (cand_sq[i] <= (2*ROOT_W)'(rad_prev[i])) ?
                                cand[i] : root_prev[i];
            end
            rad_ff[k] <= rad_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign root = root_ff[ROOT_W-1];
   assign side_out = side_ff[ROOT_W-1];

endmodule

>>> rtl/triangle_face_normal.sv
// Top level of the triangle unit face normal pipeline.
//
// One word on the req channel is one triangle: vertices a, b and c in signed
// Q16.16. One word on the rsp channel is its unit normal in signed Q1.14 and
// a degenerate flag in tuser. The normal is (c - a) x (c - b), negated when
// flip_winding is set through the csr port; a zero cross product gives a
// zero normal with the flag raised.
// Register stages: four for the edges and cross product, three for the
// reduction and sum of squares, 31 for the divider (one quotient bit per
// stage), 16 for the square root (one root bit per stage) and one for the
// output register. A new word enters every cycle in which the pipeline is not held.
// The whole pipeline moves on one enable: when the output register holds a
// word that rsp_tready does not take, every stage holds and req_tready falls,
// so nothing is lost or repeated. Reset clears all valid bits and
// flip_winding; there is no clearing pass.
module triangle_face_normal (
   input  logic                                clock,
   input  logic                                reset,
   // Fields from bit 0 up: a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z.
   input  logic [287:0]                        req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0 up: norm_x, norm_y, norm_z.
   output logic [47:0]                         rsp_tdata,
   // Fields from bit 0 up: degenerate.
   output logic [0:0]                          rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tfn_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import tfn_pkg::*;

   logic en;
   logic flip_ff;
   logic [2:0][COORD_W-1:0] vert_a;
   logic [2:0][COORD_W-1:0] vert_b;
   logic [2:0][COORD_W-1:0] vert_c;
   logic crs_valid;
   logic [2:0][CRS_W-1:0] crs_mag;
   logic [2:0] crs_neg;
   logic nrm_valid;
   logic [2:0][SQ_W-1:0] nrm_sq;
   logic [SUM_W-1:0] nrm_sum;
   side_type nrm_side;
   logic div_valid;
   logic [2:0][QUO_W-1:0] div_quo;
   side_type div_side;
   logic rt_valid;
   logic [2:0][ROOT_W-1:0] rt_root;
   side_type rt_side;
   logic [2:0][NORM_W-1:0] norm_in;
   logic [2:0][NORM_W-1:0] norm_ff;
   logic degen_ff;
   logic vld_ff;

   // Pipeline enable: move whenever the output register is free or taken.
   assign en = !vld_ff || rsp_tready;
   assign req_tready = en;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_FLIP) ? {31'd0, flip_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr == ADDR_FLIP)) begin
         flip_ff <= csr_pwdata[0];
      end
   end

   // Unpack the vertex word.
   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign vert_a[i] = req_tdata[COORD_W*i +: COORD_W];
      assign vert_b[i] = req_tdata[COORD_W*(i+3) +: COORD_W];
      assign vert_c[i] = req_tdata[COORD_W*(i+6) +: COORD_W];
   end

   tfn_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .vert_a    (vert_a),
      .vert_b    (vert_b),
      .vert_c    (vert_c),
      .out_valid (crs_valid),
      .mag       (crs_mag),
      .neg       (crs_neg)
   );

   tfn_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (crs_valid),
      .mag       (crs_mag),
      .neg       (crs_neg),
      .out_valid (nrm_valid),
      .sq        (nrm_sq),
      .sum       (nrm_sum),
      .side      (nrm_side)
   );

   tfn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nrm_valid),
      .sq        (nrm_sq),
      .sum       (nrm_sum),
      .side_in   (nrm_side),
      .out_valid (div_valid),
      .quo       (div_quo),
      .side_out  (div_side)
   );

   tfn_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .rad       (div_quo),
      .side_in   (div_side),
      .out_valid (rt_valid),
      .root      (rt_root),
      .side_out  (rt_side)
   );

   // Halve the root with rounding to nearest, apply the sign and zero a degenerate normal.
   for (genvar i = 0; i < 3; i++) begin : g_sign
      logic [ROOT_W:0] half_up;
      logic signed [ROOT_W:0] sval;
      assign half_up = {1'b0, rt_root[i]} + (ROOT_W+1)'(1);
      assign sval = (rt_side.neg[i] ^ flip_ff) ? -$signed({1'b0, half_up[ROOT_W:1]})
                                                :  $signed({1'b0, half_up[ROOT_W:1]});
      assign norm_in[i] = rt_side.degen ? '0 : NORM_W'(sval);
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= rt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         norm_ff <= norm_in;
         degen_ff <= rt_side.degen;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = norm_ff;
   assign rsp_tuser = degen_ff;

   // A degenerate word carries a zero normal.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("degenerate word with nonzero normal");

   // The x component stays within one unit.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd16384
                      && $signed(rsp_tdata[15:0]) >= -16'sd16384))
      else $error("normal x out of range");

   // The input side is held exactly when the output register is stalled.
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("pipeline enable mismatch");

   // No word leaves right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid after reset");

   // A register write lands on the next edge.
   a_flip_write: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_FLIP)
      |=> (flip_ff == $past(csr_pwdata[0])))
      else $error("flip_winding write lost");

endmodule

>>> verif/triangle_face_normal_tb.sv
// Self-checking testbench for the triangle unit face normal pipeline.
module triangle_face_normal_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tfn_pkg::*;

   localparam int SETTLE_CYCLES = 80;

   // One unit normal as it leaves the block.
   typedef struct {
      logic [NORM_W-1:0] norm_x;
      logic [NORM_W-1:0] norm_y;
      logic [NORM_W-1:0] norm_z;
      logic              degenerate;
   } face_normal_type;

   // Scoreboard: predicts each triangle's normal and checks results in order.
   class normal_scoreboard;
      face_normal_type pending_normals[$];
      bit              flip_winding;
      int              mismatches;
      int              checked;
      int              degenerate_seen;

      function new();
         flip_winding = 0;
         mismatches = 0;
         checked = 0;
         degenerate_seen = 0;
      endfunction

      // Rounded magnitude of one component scaled to unit length.
      function automatic logic [63:0] unit_mag(logic [63:0] m, logic [63:0] sum_sq);
         logic [63:0]  lo;
         logic [63:0]  hi;
         logic [63:0]  mid;
         logic [127:0] t;
         logic [127:0] lhs;
         logic [127:0] rhs;
         lo = 0;
         hi = 64'd1 << FRAC_BITS;
         rhs = 128'(2 * m) * 128'(2 * m);
         rhs = rhs << (2 * FRAC_BITS);
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 128'(2 * mid - 1);
            lhs = t * t * 128'(sum_sq);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      // Exact cross product, reduction to 31 bits and normalization.
      function automatic face_normal_type face_normal(logic [287:0] tri_word);
         logic signed [67:0] e1 [3];
         logic signed [67:0] e2 [3];
         logic signed [67:0] crs [3];
         logic [67:0]        mag [3];
         logic               neg [3];
         logic [63:0]        m [3];
         logic [63:0]        sum_sq;
         logic [63:0]        q;
         logic [15:0]        lane [3];
         int                 len;
         int                 shift;
         face_normal_type    r;
         for (int k = 0; k < 3; k++) begin
            e1[k] = 68'($signed(tri_word[32*(6+k) +: 32])) - 68'($signed(tri_word[32*k +: 32]));
            e2[k] = 68'($signed(tri_word[32*(6+k) +: 32]))
                  - 68'($signed(tri_word[32*(3+k) +: 32]));
         end
         crs[0] = e1[1] * e2[2] - e1[2] * e2[1];
         crs[1] = e1[2] * e2[0] - e1[0] * e2[2];
         crs[2] = e1[0] * e2[1] - e1[1] * e2[0];
         len = 0;
         for (int k = 0; k < 3; k++) begin
            neg[k] = crs[k] < 0;
            mag[k] = neg[k] ? -crs[k] : crs[k];
            for (int b = 0; b < 68; b++)
               if (mag[k][b] && b + 1 > len) len = b + 1;
         end
         if (len == 0) begin
            r.norm_x = '0;
            r.norm_y = '0;
            r.norm_z = '0;
            r.degenerate = 1'b1;
            return r;
         end
         shift = len > 31 ? len - 31 : 0;
         for (int k = 0; k < 3; k++) m[k] = 64'((mag[k] >> shift) & 68'h7FFF_FFFF);
         sum_sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
         for (int k = 0; k < 3; k++) begin
            q = unit_mag(m[k], sum_sq);
            lane[k] = (neg[k] ^ flip_winding) ? 16'(-q) : 16'(q);
         end
         r.norm_x = lane[0];
         r.norm_y = lane[1];
         r.norm_z = lane[2];
         r.degenerate = 1'b0;
         return r;
      endfunction

      // Called for every triangle the block accepts.
      function void note_triangle(logic [287:0] tri_word);
         pending_normals = {pending_normals, face_normal(tri_word)};
      endfunction

      task report(string what, logic [15:0] got, logic [15:0] want);
         mismatches++;
         $display("[%0t] %s mismatch: got %h, predicted %h", $realtime, what, got, want);
      endtask

      // Called for every normal the block delivers.
      task check_normal(logic [47:0] data, logic degen);
         face_normal_type want;
         if (pending_normals.size() == 0) begin
            report("unexpected word", data[15:0], 16'h0);
            return;
         end
         want = pending_normals.pop_front();
         checked++;
         if (degen) degenerate_seen++;
         if (data[15:0] !== want.norm_x) report("norm_x", data[15:0], want.norm_x);
         if (data[31:16] !== want.norm_y) report("norm_y", data[31:16], want.norm_y);
         if (data[47:32] !== want.norm_z) report("norm_z", data[47:32], want.norm_z);
         if (degen !== want.degenerate) report("degenerate", 16'(degen), 16'(want.degenerate));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic [287:0]      req_tdata;
   logic              req_tvalid;
   logic              req_tready;
   logic [47:0]       rsp_tdata;
   logic [0:0]        rsp_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   normal_scoreboard  sb;
   int                tx_idle_pct;
   int                rx_idle_pct;
   int                rx_hold_cycles;
   int                sent;

   triangle_face_normal dut (.*);

   // Clock.
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("Timeout waiting for the pipeline to drain");
      $display("Mismatches found");
      $finish;
   end

   // Monitor both channels at each rising edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_triangle(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_normal(rsp_tdata, rsp_tuser[0]);
   end

   // Receiver: random stalls, plus an occasional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_hold_cycles > 0) begin
         rx_hold_cycles <= rx_hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Offer one triangle word and wait until it is taken.
   task send_triangle(logic [287:0] tri_word);
      // Each cycle the sender stays idle with the configured chance.
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= tri_word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // The extra edge lets the monitor record a word taken on the last edge.
   task wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_normals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle then access cycle.
   task write_flip(bit value);
      wait_drained();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_FLIP;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.flip_winding = value;
   endtask

   function automatic logic [31:0] extreme_coord();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function automatic logic [287:0] pack_tri(logic [31:0] c [9]);
      logic [287:0] w;
      for (int k = 0; k < 9; k++) w[32*k +: 32] = c[k];
      return w;
   endfunction

   // Random triangle: full range, mesh-sized, extremes or degenerate shapes.
   function automatic logic [287:0] random_triangle();
      logic [31:0] c [9];
      int          kind;
      int          s;
      kind = $urandom_range(99);
      for (int k = 0; k < 9; k++) begin
         if (kind < 35) c[k] = $urandom;
         else if (kind < 75) c[k] = 32'($signed($urandom_range(0, 400000)) - 200000);
         else if (kind < 88) c[k] = extreme_coord();
         else c[k] = 32'($signed($urandom_range(0, 2000)) - 1000);
      end
      // Collinear vertices give a zero cross product.
      if (kind >= 88 && kind < 94) begin
         s = $urandom_range(0, 3);
         for (int k = 0; k < 3; k++) begin
            c[3+k] = c[k] + c[6+k];
            c[6+k] = c[k] + 32'(s) * c[6+k];
         end
      end else if (kind >= 94) begin
         for (int k = 0; k < 3; k++) c[3+k] = c[k];
      end
      return pack_tri(c);
   endfunction

   task run_random(int count, int hold_at, int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) rx_hold_cycles = 400;
         if (i == pause_at) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (sb.pending_normals.size() != 0) @(posedge clock);
         end
         send_triangle(random_triangle());
      end
   endtask

   // Main sequence.
   initial begin
      logic [31:0] c [9];
      sb = new();
      sent = 0;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold_cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: all zero, unit axes, extreme coordinates, collinear points.
      for (int k = 0; k < 9; k++) c[k] = 32'h0;
      send_triangle(pack_tri(c));
      for (int k = 0; k < 9; k++) c[k] = 32'h0;
      c[0] = 32'h0001_0000; c[4] = 32'h0001_0000;
      send_triangle(pack_tri(c));
      c[0] = 32'h0; c[4] = 32'h0; c[2] = 32'h0001_0000; c[3] = 32'h0001_0000;
      send_triangle(pack_tri(c));
      for (int k = 0; k < 9; k++) c[k] = 32'h8000_0000;
      c[6] = 32'h7FFF_FFFF; c[4] = 32'h7FFF_FFFF; c[2] = 32'h7FFF_FFFF;
      send_triangle(pack_tri(c));
      for (int k = 0; k < 9; k++) c[k] = (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      send_triangle(pack_tri(c));
      for (int k = 0; k < 9; k++) c[k] = (k < 3) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      c[7] = 32'h8000_0000;
      send_triangle(pack_tri(c));
      for (int k = 0; k < 9; k++) c[k] = 32'(k + 1);
      send_triangle(pack_tri(c));
      for (int k = 0; k < 9; k++) c[k] = 32'hFFFF_FFFF;
      send_triangle(pack_tri(c));
      for (int k = 0; k < 9; k++) c[k] = 32'h0;
      c[6] = 32'h0000_0001; c[4] = 32'h0000_0001; c[2] = 32'h0000_0001;
      send_triangle(pack_tri(c));
      for (int i = 0; i < 11; i++) begin
         for (int k = 0; k < 9; k++) c[k] = extreme_coord();
         send_triangle(pack_tri(c));
      end

      // Flipped winding, sender idles 37 percent and receiver 60 percent, with a drain pause.
      write_flip(1'b1);
      tx_idle_pct = 37;
      rx_idle_pct = 60;
      run_random(580, -1, 300);

      // Normal winding, idling swapped, with a long receiver hold-off.
      write_flip(1'b0);
      tx_idle_pct = 60;
      rx_idle_pct = 37;
      run_random(580, 200, -1);

      // Flipped again at full rate, with another hold-off.
      write_flip(1'b1);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_random(580, 100, -1);

      wait_drained();
      $display("Sent %0d triangles over both winding settings; checked %0d normals, %0d degenerate.",
               sent, sb.checked, sb.degenerate_seen);
      if (sb.mismatches == 0 && sb.pending_normals.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> triangle_face_normal.f
rtl/tfn_pkg.sv
rtl/tfn_cross.sv
rtl/tfn_norm.sv
rtl/tfn_div.sv
rtl/tfn_isqrt.sv
rtl/triangle_face_normal.sv
verif/triangle_face_normal_tb.sv
